// ----- rtl/core/fcs_pkg.sv -----
// Shared types and constants for the feature column screening core.
package fcs_pkg;

	localparam int MAX_FEATURES_DEF = 64;
	localparam int COUNT_BITS_DEF   = 24;

	localparam int FIDX_W    = 6;   // feature index / position width
	localparam int VAL_W     = 32;  // Q16.16 sample width
	localparam int FC_W      = 7;   // feature_count register width
	localparam int LIM_W     = 31;  // extreme_limit register width
	localparam int REASON_W  = 3;
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 31;

	localparam logic [FC_W-1:0]  FC_RESET    = 7'd64;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 31'd65536000;

	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTREME_LIMIT = 1'b1;

	localparam logic CMD_ACCUMULATE = 1'b0;
	localparam logic CMD_REPORT     = 1'b1;

	typedef enum logic [REASON_W-1:0] {
		RSN_KEEP      = 3'd0,
		RSN_NO_FINITE = 3'd1,
		RSN_ALL_ZERO  = 3'd2,
		RSN_EXTREME   = 3'd3,
		RSN_MISSING   = 3'd4
	} reason_t;

	// operations of the shared compare unit; each yields a < b
	typedef enum logic [2:0] {
		OP_LO   = 3'd0,  // value < min
		OP_HI   = 3'd1,  // max < value
		OP_XMAX = 3'd2,  // limit < |max|
		OP_XMIN = 3'd3,  // limit < |min|
		OP_MISS = 3'd4   // 20*finite < 19*total
	} cmp_op_t;

endpackage

// ----- rtl/core/fcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fcs_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/fcs_cmp.sv -----
// Shared signed compare unit: builds both operands for the selected check.
module fcs_cmp #(
	parameter int CW = 24
) (
	input  fcs_pkg::cmp_op_t                op,
	input  logic [fcs_pkg::VAL_W-1:0]       value,
	input  logic [fcs_pkg::VAL_W-1:0]       min_val,
	input  logic [fcs_pkg::VAL_W-1:0]       max_val,
	input  logic [CW-1:0]                   fin_cnt,
	input  logic [CW-1:0]                   tot_cnt,
	input  logic [fcs_pkg::LIM_W-1:0]       limit,
	output logic                            lt
);
	import fcs_pkg::*;

	localparam int CMPW = (CW + 6 > VAL_W + 1) ? CW + 6 : VAL_W + 1;

	logic signed [CMPW-1:0] sx_val, sx_min, sx_max, mag_sel, zx_lim, zx_fin, zx_tot;
	logic signed [CMPW-1:0] a, b;
	logic [VAL_W-1:0]       mag_src;

	assign sx_val = {{(CMPW-VAL_W){value[VAL_W-1]}}, value};
	assign sx_min = {{(CMPW-VAL_W){min_val[VAL_W-1]}}, min_val};
	assign sx_max = {{(CMPW-VAL_W){max_val[VAL_W-1]}}, max_val};
	assign zx_lim = {{(CMPW-LIM_W){1'b0}}, limit};
	assign zx_fin = {{(CMPW-CW){1'b0}}, fin_cnt};
	assign zx_tot = {{(CMPW-CW){1'b0}}, tot_cnt};

	// one negate serves both magnitude checks
	assign mag_src = (op == OP_XMIN) ? min_val : max_val;
	always_comb begin
		logic signed [CMPW-1:0] sx;
		sx = {{(CMPW-VAL_W){mag_src[VAL_W-1]}}, mag_src};
		mag_sel = mag_src[VAL_W-1] ? -sx : sx;
	end

	always_comb begin
		case (op)
			OP_LO: begin
				a = sx_val;
				b = sx_min;
			end
			OP_HI: begin
				a = sx_max;
				b = sx_val;
			end
			OP_XMAX, OP_XMIN: begin
				a = zx_lim;
				b = mag_sel;
			end
			OP_MISS: begin
				a = (zx_fin <<< 4) + (zx_fin <<< 2);
				b = (zx_tot <<< 4) + (zx_tot <<< 1) + zx_tot;
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	assign lt = a < b;

endmodule

// ----- rtl/core/feature_column_screening_core.sv -----
// Top level: per-feature statistics store, sequencer and verdict output.
//
//  channel  dir  handshake                payload
//  s_*      in   s_tvalid / s_tready      tdata: feature_index, sample_value; tuser: cmd, finite
//  m_*      out  m_tvalid / m_tready      tdata: feature, reason, position; tuser: keep; tlast
//  cfg_*    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Accumulate: READ, LOAD, WRITE; LO and HI precede WRITE for a finite sample on a feature
// that already holds a min/max. A request for a feature out of range is dropped in IDLE.
// The shared comparator runs the min, max, magnitude and missing-ratio checks in turn. Report:
// READ, LOAD, the due checks and EMIT per feature, plus output stalls; the store is cleared at
// its end via per-entry valid bits, which reset also clears. No clearing pass is needed.
module feature_column_screening_core #(
	parameter int MAX_FEATURES = fcs_pkg::MAX_FEATURES_DEF,
	parameter int COUNT_BITS   = fcs_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fcs_pkg::S_TDATA_W-1:0]     s_tdata,  // [5:0] feature_index, [37:6] sample_value
	input  logic [fcs_pkg::S_TUSER_W-1:0]     s_tuser,  // [0] cmd, [1] sample_finite
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fcs_pkg::M_TDATA_W-1:0]     m_tdata,  // [5:0] verdict_feature, [8:6] drop_reason,
	                                                    // [14:9] kept_position
	output logic                              m_tuser,  // [0] keep
	output logic                              m_tlast,  // last_verdict
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fcs_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import fcs_pkg::*;

	localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int EW = 2 * VAL_W + 2 * COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_READ  = 10'b0000000010,
		ST_LOAD  = 10'b0000000100,
		ST_LO    = 10'b0000001000,
		ST_HI    = 10'b0000010000,
		ST_WRITE = 10'b0000100000,
		ST_XMAX  = 10'b0001000000,
		ST_XMIN  = 10'b0010000000,
		ST_MISS  = 10'b0100000000,
		ST_EMIT  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [FC_W-1:0]       fc_q;
	logic [LIM_W-1:0]      lim_q;
	logic [FC_W-1:0]       n_eff;

	logic                  cmd_q, fin_flag_q;
	logic [FIDX_W-1:0]     idx_q, pos_q;
	logic [VAL_W-1:0]      val_q, min_q, max_q;
	logic [COUNT_BITS-1:0] fin_q, tot_q, fin_n, tot_n;
	reason_t               reason_q;
	logic [MAX_FEATURES-1:0] vld_q;

	logic                  ram_we;
	logic [EW-1:0]         ram_wdata, ram_rdata;
	logic                  ent_vld;
	logic [VAL_W-1:0]      ent_min, ent_max;
	logic [COUNT_BITS-1:0] ent_fin, ent_tot;

	cmp_op_t               op;
	logic                  lt;

	logic [FIDX_W-1:0]     in_idx;
	logic                  in_acc, in_range, is_last, out_free, emit_go;

	logic [FIDX_W-1:0]     out_feat_q, out_pos_q;
	reason_t               out_reason_q;
	logic                  out_keep_q, out_last_q, m_tvalid_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= FC_RESET;
			lim_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FEATURE_COUNT: fc_q  <= cfg_data[FC_W-1:0];
				REG_EXTREME_LIMIT: lim_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fc_q == '0) begin
			n_eff = FC_W'(1);
		end else if (fc_q > FC_W'(MAX_FEATURES)) begin
			n_eff = FC_W'(MAX_FEATURES);
		end else begin
			n_eff = fc_q;
		end
	end

	// statistics store
	fcs_ram #(
		.W     (EW),
		.DEPTH (MAX_FEATURES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// entries never written since reset or the last report read as zero
	assign ent_vld = vld_q[idx_q[AW-1:0]];
	assign ent_min = ent_vld ? ram_rdata[VAL_W-1:0] : '0;
	assign ent_max = ent_vld ? ram_rdata[2*VAL_W-1:VAL_W] : '0;
	assign ent_fin = ent_vld ? ram_rdata[2*VAL_W +: COUNT_BITS] : '0;
	assign ent_tot = ent_vld ? ram_rdata[2*VAL_W+COUNT_BITS +: COUNT_BITS] : '0;

	assign tot_n = (tot_q == CNT_MAX) ? tot_q : tot_q + COUNT_BITS'(1);
	assign fin_n = (fin_flag_q && fin_q != CNT_MAX) ? fin_q + COUNT_BITS'(1) : fin_q;

	assign ram_we    = (state_q == ST_WRITE);
	assign ram_wdata = {tot_n, fin_n, max_q, min_q};

	// shared compare unit
	always_comb begin
		case (state_q)
			ST_LO:   op = OP_LO;
			ST_HI:   op = OP_HI;
			ST_XMAX: op = OP_XMAX;
			ST_XMIN: op = OP_XMIN;
			ST_MISS: op = OP_MISS;
			default: op = OP_LO;
		endcase
	end

	fcs_cmp #(
		.CW (COUNT_BITS)
	) u_cmp (
		.op      (op),
		.value   (val_q),
		.min_val (min_q),
		.max_val (max_q),
		.fin_cnt (fin_q),
		.tot_cnt (tot_q),
		.limit   (lim_q),
		.lt      (lt)
	);

	// sequencer
	assign s_tready = (state_q == ST_IDLE);
	assign in_idx   = s_tdata[FIDX_W-1:0];
	assign in_acc   = (s_tuser[0] == CMD_ACCUMULATE);
	assign in_range = {1'b0, in_idx} < n_eff;
	assign is_last  = ({1'b0, idx_q} + FC_W'(1)) == n_eff;
	assign out_free = !m_tvalid_q || m_tready;
	assign emit_go  = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_q   <= '0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (!in_acc) begin
							pos_q   <= '0;
							state_q <= ST_READ;
						end else if (in_range) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (cmd_q == CMD_ACCUMULATE) begin
						if (fin_flag_q && ent_fin != '0) begin
							state_q <= ST_LO;
						end else begin
							state_q <= ST_WRITE;
						end
					end else if (ent_fin == '0 || (ent_min == '0 && ent_max == '0)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_XMAX;
					end
				end
				ST_LO:   state_q <= ST_HI;
				ST_HI:   state_q <= ST_WRITE;
				ST_WRITE: begin
					vld_q[idx_q[AW-1:0]] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_XMAX: state_q <= lt ? ST_EMIT : ST_XMIN;
				ST_XMIN: state_q <= lt ? ST_EMIT : ST_MISS;
				ST_MISS: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						if (reason_q == RSN_KEEP) begin
							pos_q <= pos_q + FIDX_W'(1);
						end
						if (is_last) begin
							vld_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q      <= s_tuser[0];
				fin_flag_q <= s_tuser[1];
				val_q      <= s_tdata[FIDX_W +: VAL_W];
				idx_q      <= in_acc ? in_idx : '0;
			end
			ST_LOAD: begin
				fin_q <= ent_fin;
				tot_q <= ent_tot;
				if (cmd_q == CMD_ACCUMULATE && fin_flag_q && ent_fin == '0) begin
					min_q <= val_q;
					max_q <= val_q;
				end else begin
					min_q <= ent_min;
					max_q <= ent_max;
				end
				if (ent_fin == '0) begin
					reason_q <= RSN_NO_FINITE;
				end else if (ent_min == '0 && ent_max == '0) begin
					reason_q <= RSN_ALL_ZERO;
				end
			end
			ST_LO: begin
				if (lt) min_q <= val_q;
			end
			ST_HI: begin
				if (lt) max_q <= val_q;
			end
			ST_XMAX, ST_XMIN: begin
				if (lt) reason_q <= RSN_EXTREME;
			end
			ST_MISS: begin
				reason_q <= lt ? RSN_MISSING : RSN_KEEP;
			end
			ST_EMIT: begin
				if (out_free && !is_last) idx_q <= idx_q + FIDX_W'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_feat_q   <= idx_q;
			out_reason_q <= reason_q;
			out_keep_q   <= (reason_q == RSN_KEEP);
			out_pos_q    <= (reason_q == RSN_KEEP) ? pos_q : '0;
			out_last_q   <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_pos_q, out_reason_q, out_feat_q};
	assign m_tuser  = out_keep_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- tb/sv/tb_feature_column_screening_core.sv -----
// Self-checking testbench for feature_column_screening_core with a verdict scoreboard.
module tb_feature_column_screening_core;
	import fcs_pkg::*;

	localparam int CYCLE_LIMIT    = 3000000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int ITEM_TARGET    = 385;
	localparam int QUIET_AFTER    = 330;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int HOLD_PHASE     = 6;

	typedef struct packed {
		logic [FIDX_W-1:0] feature;
		logic              keep;
		reason_t           reason;
		logic [FIDX_W-1:0] position;
		logic              last;
	} verdict_t;

	class verdict_scoreboard;
		logic signed [VAL_W-1:0] col_min [MAX_FEATURES_DEF];
		logic signed [VAL_W-1:0] col_max [MAX_FEATURES_DEF];
		logic [COUNT_BITS_DEF-1:0] finite_cnt [MAX_FEATURES_DEF];
		logic [COUNT_BITS_DEF-1:0] total_cnt [MAX_FEATURES_DEF];
		logic [FC_W-1:0]  column_reg;
		logic [LIM_W-1:0] limit_reg;
		verdict_t verdicts_due[$];
		int errors;

		function new();
			column_reg = FC_RESET;
			limit_reg  = LIMIT_RESET;
			errors     = 0;
			clear_columns();
		endfunction

		function void clear_columns();
			for (int c = 0; c < MAX_FEATURES_DEF; c++) begin
				col_min[c]    = '0;
				col_max[c]    = '0;
				finite_cnt[c] = '0;
				total_cnt[c]  = '0;
			end
		endfunction

		function int active_columns();
			if (column_reg == 0)
				return 1;
			if (column_reg > MAX_FEATURES_DEF)
				return MAX_FEATURES_DEF;
			return int'(column_reg);
		endfunction

		function int waiting();
			return verdicts_due.size();
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			if (idx == REG_FEATURE_COUNT)
				column_reg = data[FC_W-1:0];
			else
				limit_reg = data[LIM_W-1:0];
		endfunction

		function logic [VAL_W:0] magnitude(logic signed [VAL_W-1:0] v);
			logic signed [VAL_W:0] w;
			w = v;
			return (w < 0) ? -w : w;
		endfunction

		function reason_t screen_column(int c);
			logic [63:0] finite_x20;
			logic [63:0] total_x19;
			finite_x20 = 64'(finite_cnt[c]) * 64'd20;
			total_x19  = 64'(total_cnt[c]) * 64'd19;
			if (finite_cnt[c] == 0)
				return RSN_NO_FINITE;
			if (col_min[c] == 0 && col_max[c] == 0)
				return RSN_ALL_ZERO;
			if (magnitude(col_max[c]) > {2'b00, limit_reg} ||
			    magnitude(col_min[c]) > {2'b00, limit_reg})
				return RSN_EXTREME;
			if (finite_x20 < total_x19)
				return RSN_MISSING;
			return RSN_KEEP;
		endfunction

		function void note_request(logic cmd, logic [FIDX_W-1:0] col,
		                           logic signed [VAL_W-1:0] value, logic finite);
			int n;
			int pos;
			verdict_t v;
			n = active_columns();
			if (cmd == CMD_ACCUMULATE) begin
				if (int'(col) >= n)
					return;
				if (total_cnt[col] != '1)
					total_cnt[col]++;
				if (finite) begin
					if (finite_cnt[col] == 0) begin
						col_min[col] = value;
						col_max[col] = value;
					end else begin
						if (value < col_min[col])
							col_min[col] = value;
						if (value > col_max[col])
							col_max[col] = value;
					end
					if (finite_cnt[col] != '1)
						finite_cnt[col]++;
				end
				return;
			end
			pos = 0;
			for (int c = 0; c < n; c++) begin
				v.feature  = FIDX_W'(c);
				v.reason   = screen_column(c);
				v.keep     = (v.reason == RSN_KEEP);
				v.position = v.keep ? FIDX_W'(pos) : '0;
				v.last     = (c == n - 1);
				if (v.keep)
					pos++;
				verdicts_due.insert(verdicts_due.size(), v);
			end
			clear_columns();
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				$error("verdict for feature %0d with nothing expected", got.feature);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			compare_field("verdict_feature", want.feature, got.feature);
			compare_field("keep", want.keep, got.keep);
			compare_field("drop_reason", want.reason, got.reason);
			compare_field("kept_position", want.position, got.position);
			compare_field("last_verdict", want.last, got.last);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	verdict_scoreboard sb = new();
	int  cycle_count = 0;
	int  item_count = 0;
	bit  quiet_tail = 1'b0;
	bit  rx_hold_req = 1'b0;

	feature_column_screening_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// verdict monitor
	always @(posedge clk) begin
		verdict_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.feature  = m_tdata[5:0];
			got.reason   = reason_t'(m_tdata[8:6]);
			got.position = m_tdata[14:9];
			got.keep     = m_tuser;
			got.last     = m_tlast;
			sb.check_verdict(got);
		end
	end

	// receiver: ready runs broken by stall bursts, plus one long hold-off on request
	initial begin
		int run_len;
		run_len = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
			end else if (quiet_tail || run_len > 0) begin
				m_tready <= 1'b1;
				if (run_len > 0)
					run_len--;
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
				run_len = $urandom_range(1, 40);
			end
		end
	end

	task automatic sender_gap(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic push_request(logic cmd, logic [FIDX_W-1:0] col, logic [VAL_W-1:0] value,
	                            logic finite);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, value, col};
		s_tuser  <= {finite, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(cmd, col, value, finite);
		item_count++;
		if (item_count >= QUIET_AFTER)
			quiet_tail = 1'b1;
		if (!quiet_tail && $urandom_range(0, 3) == 0)
			sender_gap($urandom_range(1, 13));
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// accumulate requests cause no verdict, so give the block time to finish them too
	task automatic drain_and_settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value(logic [LIM_W-1:0] lim, int zero_pct);
		logic [31:0] r;
		r = $urandom();
		if ($urandom_range(0, 99) < zero_pct)
			return '0;
		case ($urandom_range(0, 5))
			0: return {1'b0, lim} + 32'($urandom_range(0, 2)) - 32'd1;
			1: return -{1'b0, lim} + 32'($urandom_range(0, 2)) - 32'd1;
			2: return r;
			3: return 32'($urandom_range(0, 2000)) - 32'd1000;
			4: return r[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return {{12{r[19]}}, r[19:0]};
		endcase
	endfunction

	task automatic random_item(int n_eff, logic [LIM_W-1:0] lim, int zero_pct);
		logic [FIDX_W-1:0] col;
		logic [VAL_W-1:0]  value;
		logic              finite;
		col    = ($urandom_range(0, 9) == 0) ? FIDX_W'($urandom_range(0, 63))
		                                     : FIDX_W'($urandom_range(0, n_eff - 1));
		value  = pick_value(lim, zero_pct);
		finite = ($urandom_range(0, 11) != 0);
		if ($urandom_range(0, 99) < 3)
			push_request(CMD_REPORT, col, value, finite);
		else
			push_request(CMD_ACCUMULATE, col, value, finite);
	endtask

	// columns sitting near the 95% finite boundary
	task automatic ratio_columns(int n_eff);
		int finite_left;
		int total_left;
		logic finite;
		for (int c = 0; c < n_eff && c < 3; c++) begin
			finite_left = $urandom_range(17, 20);
			total_left  = finite_left + $urandom_range(0, 2);
			while (total_left > 0) begin
				finite = ($urandom_range(1, total_left) <= finite_left);
				push_request(CMD_ACCUMULATE, FIDX_W'(c), 32'($urandom_range(1, 65536)), finite);
				if (finite)
					finite_left--;
				total_left--;
			end
		end
	endtask

	initial begin
		int phase;
		int fc;
		int n_eff;
		int zero_pct;
		logic [LIM_W-1:0] lim;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FEATURE_COUNT;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset configuration: 64 columns, limit 1000.0
		push_request(CMD_ACCUMULATE, 6'd0, 32'h1234_5678, 1'b0);
		push_request(CMD_ACCUMULATE, 6'd1, 32'd0, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd1, 32'd0, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd2, 32'h8000_0000, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd3, 32'd65536000, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd3, -32'd65536000, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd3, 32'd5, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd4, 32'd7, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd4, 32'd9, 1'b0);
		push_request(CMD_ACCUMULATE, 6'd5, -32'd65536001, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd6, 32'd65536001, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd7, 32'd3, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd7, -32'd2, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd63, 32'h7FFF_FFFF, 1'b1);
		push_request(CMD_REPORT, 6'd0, 32'd0, 1'b0);
		drain_and_settle();

		// zero column count acts as one column; the rest is ignored
		write_register(REG_FEATURE_COUNT, 31'h7FFF_FF80);
		write_register(REG_EXTREME_LIMIT, 31'h7FFF_FFFF);
		push_request(CMD_ACCUMULATE, 6'd0, 32'h8000_0000, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd1, 32'd5, 1'b1);
		push_request(CMD_ACCUMULATE, 6'd63, 32'd5, 1'b1);
		push_request(CMD_REPORT, 6'd63, 32'hFFFF_FFFF, 1'b1);

		phase = 0;
		while (item_count < ITEM_TARGET) begin
			drain_and_settle();
			case (phase % 6)
				0: begin fc = 64;  lim = LIM_W'($urandom()); end
				1: begin fc = 0;   lim = 31'h7FFF_FFFF; end
				2: begin fc = $urandom_range(2, 8); lim = LIMIT_RESET; end
				3: begin fc = 127; lim = '0; end
				4: begin fc = 1;   lim = LIM_W'($urandom()); end
				default: begin fc = $urandom_range(1, 64); lim = LIM_W'($urandom_range(0, 1 << 20)); end
			endcase
			if (phase % 5 == 3)
				lim = 31'h7FFF_FFFF;
			write_register(REG_FEATURE_COUNT, (LIM_W'($urandom()) & ~31'h7F) | LIM_W'(fc));
			write_register(REG_EXTREME_LIMIT, lim);
			n_eff = sb.active_columns();
			zero_pct = (phase % 4 == 1) ? 70 : 8;
			if (phase == HOLD_PHASE) begin
				// receiver stalls a full report while new requests keep coming
				rx_hold_req = 1'b1;
				push_request(CMD_REPORT, 6'd0, 32'd0, 1'b0);
			end
			if (phase % 5 == 3)
				ratio_columns(n_eff);
			else
				repeat ($urandom_range(15, 40)) random_item(n_eff, lim, zero_pct);
			push_request(CMD_REPORT, FIDX_W'($urandom()), $urandom(), 1'b0);
			phase++;
		end

		drain_and_settle();
		if (sb.errors == 0 && sb.waiting() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- feature_column_screening_core.f -----
rtl/core/fcs_pkg.sv
rtl/core/fcs_ram.sv
rtl/core/fcs_cmp.sv
rtl/core/feature_column_screening_core.sv
tb/sv/tb_feature_column_screening_core.sv
